// ===== rtl/gaussian_product_expansion_coeff_core_defines.svh =====
// Assertion helpers for the expansion coefficient core.
`ifndef GAUSSIAN_PRODUCT_EXPANSION_COEFF_CORE_DEFINES_SVH
`define GAUSSIAN_PRODUCT_EXPANSION_COEFF_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge out of reset.
`define GPEC_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
// Next-cycle implication, checked on every rising edge out of reset.
`define GPEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define GPEC_ASSERT_HOLDS(label, clk, rst_n, ante, cons)
`define GPEC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/gpec_pkg.sv =====
package gpec_pkg;

	localparam int MAX_L_DEF     = 7;
	localparam int FRAC_BITS_DEF = 24;

	// Binomial table covers n, r in 0..15
	localparam int BINOM_N = 16;
	localparam int BINOM_W = 13;

	localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] SAT_MIN = 64'sh8000_0000_0000_0000;

	typedef logic [BINOM_N*BINOM_N-1:0][BINOM_W-1:0] binom_tab_t;

	// Build Pascal's triangle, row n at index n*BINOM_N + r
	function automatic binom_tab_t binom_build();
		binom_tab_t t;
		t = '0;
		for (int n = 0; n < BINOM_N; n++) begin
			for (int r = 0; r < BINOM_N; r++) begin
				if (r == 0) begin
					t[n*BINOM_N+r] = BINOM_W'(1);
				end else if (n > 0) begin
					t[n*BINOM_N+r] = t[(n-1)*BINOM_N+r-1] + t[(n-1)*BINOM_N+r];
				end
			end
		end
		return t;
	endfunction

	localparam binom_tab_t BINOM_TAB = binom_build();

	typedef struct packed {
		logic [3:0]         power_index;
		logic [2:0]         exp_first;
		logic [2:0]         exp_second;
		logic signed [31:0] offset_first;
		logic signed [31:0] offset_second;
	} gpec_in_t;

	typedef struct packed {
		logic signed [63:0] coefficient;
		logic               index_error;
		logic               overflowed;
	} gpec_out_t;

	typedef struct packed {
		logic start;
		logic fixed_mode;
	} gpec_mul_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic sat;
	} gpec_mul_rsp_t;

	typedef enum logic [1:0] {
		MU_IDLE,
		MU_RUN,
		MU_FIN
	} mu_state_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POW_A,
		ST_POW_B,
		ST_TERM_MUL,
		ST_TERM_CA,
		ST_TERM_CB
	} gpec_state_t;

endpackage

// ===== rtl/gpec_mul_unit.sv =====
module gpec_mul_unit #(
	parameter int FRAC_BITS = gpec_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gpec_pkg::gpec_mul_req_t req,
	input  logic signed [63:0]    op_x,
	input  logic signed [63:0]    op_y,
	output gpec_pkg::gpec_mul_rsp_t rsp,
	output logic signed [63:0]    product
);
	import gpec_pkg::*;

	localparam logic [127:0] HALF_LSB  = 128'(1) << (FRAC_BITS - 1);
	localparam logic [1:0]   LAST_STEP = 2'd3;

	mu_state_t    state_q, state_d;
	logic [63:0]  mag_x_q, mag_y_q;
	logic         neg_q, fixed_q;
	logic [1:0]   step_q;
	logic [127:0] acc_q;
	logic [31:0]  part_x, part_y;
	logic [63:0]  pp;
	logic [127:0] pp_shifted, rounded, scaled;
	logic         sat;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MU_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == MU_IDLE) begin
				step_q <= '0;
			end else if (state_q == MU_RUN) begin
				step_q <= step_q + 2'd1;
			end
		end
	end

	// Next state: four partial products, then the finishing state MU_FIN
	always_comb begin
		state_d = state_q;
		case (state_q)
			MU_IDLE: if (req.start) state_d = MU_RUN;
			MU_RUN:  if (step_q == LAST_STEP) state_d = MU_FIN;
			MU_FIN:  state_d = MU_IDLE;
			default: state_d = MU_IDLE;
		endcase
	end

	// Pick 32-bit halves: lo*lo, lo*hi, hi*lo, hi*hi
	assign part_x = step_q[1] ? mag_x_q[63:32] : mag_x_q[31:0];
	assign part_y = step_q[0] ? mag_y_q[63:32] : mag_y_q[31:0];
	assign pp     = {32'd0, part_x} * {32'd0, part_y};

	always_comb begin
		case (step_q)
			2'd0:    pp_shifted = {64'd0, pp};
			2'd3:    pp_shifted = {pp, 64'd0};
			default: pp_shifted = {32'd0, pp, 32'd0};
		endcase
	end

	// Latch operand magnitudes and accumulate partial products
	always_ff @(posedge clk) begin
		if (state_q == MU_IDLE && req.start) begin
			mag_x_q <= op_x[63] ? (~op_x + 64'd1) : op_x;
			mag_y_q <= op_y[63] ? (~op_y + 64'd1) : op_y;
			neg_q   <= op_x[63] ^ op_y[63];
			fixed_q <= req.fixed_mode;
			acc_q   <= '0;
		end else if (state_q == MU_RUN) begin
			acc_q <= acc_q + pp_shifted;
		end
	end

	// Round half away from zero, rescale, apply sign and saturate
	assign rounded = fixed_q ? (acc_q + HALF_LSB) : acc_q;
	assign scaled  = fixed_q ? (rounded >> FRAC_BITS) : rounded;

	always_comb begin
		sat     = 1'b0;
		product = scaled[63:0];
		if (neg_q) begin
			if ((|scaled[127:64]) || (scaled[63] && (|scaled[62:0]))) begin
				sat     = 1'b1;
				product = SAT_MIN;
			end else begin
				product = ~scaled[63:0] + 64'd1;
			end
		end else if (|scaled[127:63]) begin
			sat     = 1'b1;
			product = SAT_MAX;
		end
	end

	assign rsp.busy = (state_q != MU_IDLE);
	assign rsp.done = (state_q == MU_FIN);
	assign rsp.sat  = sat;

endmodule

// ===== rtl/gaussian_product_expansion_coeff_core.sv =====
// Returns the coefficient of x^k in (x+pA)^a * (x+pB)^b in Q39.24 from Q7.24 offsets,
// rounding each fixed-point product half away from zero and saturating every step.
// Pulse start with cmd while busy is low; the result appears on result with done high for
// exactly one cycle and cannot be held off, so capture it then. All work runs through one
// 32x32 multiplier with a 128-bit accumulator, one multiply at a time. Each item first
// builds the powers of pA and then of pB up to the highest ones the sum needs (none when
// flushed), then takes three multiplies per term: the power product, times C(a,i), then
// times C(b,k-i). An index error returns in the next cycle.
// Write flush_threshold only while busy is low and no result is pending.
`include "gaussian_product_expansion_coeff_core_defines.svh"

module gaussian_product_expansion_coeff_core #(
	parameter int MAX_L     = gpec_pkg::MAX_L_DEF,
	parameter int FRAC_BITS = gpec_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  gpec_pkg::gpec_in_t cmd,
	output logic               busy,
	output logic               done,
	output gpec_pkg::gpec_out_t result,
	input  logic               flush_we,
	input  logic [30:0]        flush_wdata
);
	import gpec_pkg::*;

	localparam int EXP_W = (MAX_L > 1) ? $clog2(MAX_L + 1) : 1;
	localparam int CNT_W = $clog2(MAX_L + 2);
	localparam logic [3:0]         MAX_L_W = 4'(MAX_L);
	localparam logic signed [63:0] FX_ONE  = 64'(1) << FRAC_BITS;

	gpec_state_t state_q, state_d;

	logic [30:0] thr_q;
	logic        done_q;
	gpec_out_t   result_q;

	// Item registers
	logic [3:0]             k_q;
	logic [2:0]             a_q, b_q, i_q, hi_q;
	logic [EXP_W-1:0]       ea_q, eb_q;
	logic signed [31:0]     pa_q, pb_q;
	logic                   flush_a_q, flush_b_q;
	logic [CNT_W-1:0]       cnt_q;
	logic signed [63:0]     run_q, term_q, acc_q;
	logic                   ov_q;
	logic signed [63:0]     pow_a_q [MAX_L+1];
	logic signed [63:0]     pow_b_q [MAX_L+1];

	// Command decode
	logic [3:0]  a4, b4, lo4, hi4, ea4, eb4;
	logic        cmd_err;
	logic [31:0] mag_a, mag_b;

	// Term operands
	logic [2:0]         ea_cur, eb_cur;
	logic [3:0]         j4;
	logic signed [63:0] pow_a_sel, pow_b_sel, pa_ext, pb_ext;
	logic [63:0]        binom_a_ext, binom_b_ext;
	logic               pow_a_end, pow_b_end, last_term;

	// Shared multiplier
	gpec_mul_req_t      mul_req;
	gpec_mul_rsp_t      mul_rsp;
	logic signed [63:0] mul_x, mul_y, mul_product;

	// Saturating accumulate
	logic signed [63:0] sum_raw, sum_sat;
	logic               add_ov;

	gpec_mul_unit #(
		.FRAC_BITS(FRAC_BITS)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.op_x   (mul_x),
		.op_y   (mul_y),
		.rsp    (mul_rsp),
		.product(mul_product)
	);

	// Decode summation bounds and highest powers needed
	assign a4      = {1'b0, cmd.exp_first};
	assign b4      = {1'b0, cmd.exp_second};
	assign cmd_err = (a4 > MAX_L_W) || (b4 > MAX_L_W) || (cmd.power_index > (a4 + b4));
	assign lo4     = (cmd.power_index > b4) ? (cmd.power_index - b4) : 4'd0;
	assign hi4     = (cmd.power_index < a4) ? cmd.power_index : a4;
	assign ea4     = a4 - lo4;
	assign eb4     = b4 - cmd.power_index + hi4;
	assign mag_a   = cmd.offset_first[31] ? (~cmd.offset_first + 32'd1) : cmd.offset_first;
	assign mag_b   = cmd.offset_second[31] ? (~cmd.offset_second + 32'd1) : cmd.offset_second;

	// Select term operands for index i
	assign pa_ext = {{32{pa_q[31]}}, pa_q};
	assign pb_ext = {{32{pb_q[31]}}, pb_q};
	assign ea_cur = a_q - i_q;
	assign j4     = k_q - {1'b0, i_q};
	assign eb_cur = 3'({1'b0, b_q} - j4);

	always_comb begin
		if (ea_cur == 3'd0) begin
			pow_a_sel = FX_ONE;
		end else if (flush_a_q) begin
			pow_a_sel = '0;
		end else begin
			pow_a_sel = pow_a_q[EXP_W'(ea_cur)];
		end
		if (eb_cur == 3'd0) begin
			pow_b_sel = FX_ONE;
		end else if (flush_b_q) begin
			pow_b_sel = '0;
		end else begin
			pow_b_sel = pow_b_q[EXP_W'(eb_cur)];
		end
	end

	assign binom_a_ext = {{(64-BINOM_W){1'b0}}, BINOM_TAB[{1'b0, a_q, 1'b0, i_q}]};
	assign binom_b_ext = {{(64-BINOM_W){1'b0}}, BINOM_TAB[{1'b0, b_q, j4}]};

	assign pow_a_end = flush_a_q || (cnt_q > CNT_W'(ea_q));
	assign pow_b_end = flush_b_q || (cnt_q > CNT_W'(eb_q));
	assign last_term = (i_q == hi_q);

	// Saturating add of the finished term
	assign sum_raw = acc_q + mul_product;
	always_comb begin
		add_ov  = 1'b0;
		sum_sat = sum_raw;
		if (!acc_q[63] && !mul_product[63] && sum_raw[63]) begin
			add_ov  = 1'b1;
			sum_sat = SAT_MAX;
		end else if (acc_q[63] && mul_product[63] && !sum_raw[63]) begin
			add_ov  = 1'b1;
			sum_sat = SAT_MIN;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			thr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (flush_we) begin
				thr_q <= flush_wdata;
			end
			done_q <= (state_q == ST_IDLE && start && cmd_err) ||
			          (state_q == ST_TERM_CB && mul_rsp.done && last_term);
		end
	end

	// Sequencer: next state and multiplier operands
	always_comb begin
		state_d            = state_q;
		mul_req.start      = 1'b0;
		mul_req.fixed_mode = 1'b1;
		mul_x              = run_q;
		mul_y              = pa_ext;
		case (state_q)
			ST_IDLE: begin
				if (start && !cmd_err) state_d = ST_POW_A;
			end
			ST_POW_A: begin
				if (pow_a_end) state_d = ST_POW_B;
				else mul_req.start = !mul_rsp.busy;
			end
			ST_POW_B: begin
				mul_y = pb_ext;
				if (pow_b_end) state_d = ST_TERM_MUL;
				else mul_req.start = !mul_rsp.busy;
			end
			ST_TERM_MUL: begin
				mul_x         = pow_a_sel;
				mul_y         = pow_b_sel;
				mul_req.start = !mul_rsp.busy;
				if (mul_rsp.done) state_d = ST_TERM_CA;
			end
			ST_TERM_CA: begin
				mul_x              = term_q;
				mul_y              = binom_a_ext;
				mul_req.fixed_mode = 1'b0;
				mul_req.start      = !mul_rsp.busy;
				if (mul_rsp.done) state_d = ST_TERM_CB;
			end
			ST_TERM_CB: begin
				mul_x              = term_q;
				mul_y              = binom_b_ext;
				mul_req.fixed_mode = 1'b0;
				mul_req.start      = !mul_rsp.busy;
				if (mul_rsp.done) state_d = last_term ? ST_IDLE : ST_TERM_MUL;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath: latch the item, build powers, accumulate terms
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					k_q       <= cmd.power_index;
					a_q       <= cmd.exp_first;
					b_q       <= cmd.exp_second;
					pa_q      <= cmd.offset_first;
					pb_q      <= cmd.offset_second;
					flush_a_q <= mag_a < {1'b0, thr_q};
					flush_b_q <= mag_b < {1'b0, thr_q};
					ea_q      <= EXP_W'(ea4);
					eb_q      <= EXP_W'(eb4);
					i_q       <= 3'(lo4);
					hi_q      <= 3'(hi4);
					cnt_q     <= CNT_W'(1);
					run_q     <= FX_ONE;
					acc_q     <= '0;
					ov_q      <= 1'b0;
					if (cmd_err) begin
						result_q.coefficient <= '0;
						result_q.index_error <= 1'b1;
						result_q.overflowed  <= 1'b0;
					end
				end
			end
			ST_POW_A: begin
				if (pow_a_end) begin
					cnt_q <= CNT_W'(1);
					run_q <= FX_ONE;
				end else if (mul_rsp.done) begin
					pow_a_q[cnt_q[EXP_W-1:0]] <= mul_product;
					run_q <= mul_product;
					cnt_q <= cnt_q + CNT_W'(1);
					ov_q  <= ov_q | mul_rsp.sat;
				end
			end
			ST_POW_B: begin
				if (!pow_b_end && mul_rsp.done) begin
					pow_b_q[cnt_q[EXP_W-1:0]] <= mul_product;
					run_q <= mul_product;
					cnt_q <= cnt_q + CNT_W'(1);
					ov_q  <= ov_q | mul_rsp.sat;
				end
			end
			ST_TERM_MUL, ST_TERM_CA: begin
				if (mul_rsp.done) begin
					term_q <= mul_product;
					ov_q   <= ov_q | mul_rsp.sat;
				end
			end
			ST_TERM_CB: begin
				if (mul_rsp.done) begin
					acc_q <= sum_sat;
					ov_q  <= ov_q | mul_rsp.sat | add_ov;
					i_q   <= i_q + 3'd1;
					if (last_term) begin
						result_q.coefficient <= sum_sat;
						result_q.index_error <= 1'b0;
						result_q.overflowed  <= ov_q | mul_rsp.sat | add_ov;
					end
				end
			end
			default: begin
				ov_q <= ov_q;
			end
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// Checks
	`GPEC_ASSERT_HOLDS(a_err_clean, clk, arst_n, done && result.index_error, result.coefficient == '0 && !result.overflowed)
	`GPEC_ASSERT_NEXT(a_accept_reacts, clk, arst_n, start && !busy, busy || done)
	`GPEC_ASSERT_HOLDS(a_done_idle, clk, arst_n, done, !busy)
	`GPEC_ASSERT_HOLDS(a_mul_in_item, clk, arst_n, mul_rsp.busy, busy)

endmodule
